>>> sv/lcswt_pkg.sv
// ---------------------------------------------------------------------------
// lcswt_pkg
// Shared constants for the LCS-with-traceback core: commands, traceback
// directions and default sizes.
// ---------------------------------------------------------------------------
package lcswt_pkg;

  localparam int DEF_MAX_LEN     = 64;
  localparam int DEF_SYMBOL_BITS = 8;

  localparam logic [1:0] CMD_APPEND_A = 2'd0;
  localparam logic [1:0] CMD_APPEND_B = 2'd1;
  localparam logic [1:0] CMD_RUN      = 2'd2;

  localparam logic [1:0] DIR_DIAG = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;

endpackage

>>> sv/lcswt_cell.sv
// ---------------------------------------------------------------------------
// lcswt_cell
// One column of the systolic score array: holds one symbol of the second
// string and the column's running score, keeps the traceback direction of
// every row of its column in a small memory.
// ---------------------------------------------------------------------------
module lcswt_cell #(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8,
  parameter int LW          = 7,
  parameter int RW          = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clr,
  input  logic                   b_we,
  input  logic [SYMBOL_BITS-1:0] b_in,
  input  logic                   vld_in,
  input  logic [SYMBOL_BITS-1:0] a_in,
  input  logic [RW-1:0]          row_in,
  input  logic [LW-1:0]          left_in,
  input  logic [LW-1:0]          diag_in,
  output logic                   vld_out,
  output logic [SYMBOL_BITS-1:0] a_out,
  output logic [RW-1:0]          row_out,
  output logic [LW-1:0]          left_out,
  output logic [LW-1:0]          diag_out,
  input  logic [RW-1:0]          rd_addr,
  output logic [1:0]             rd_dir,
  output logic [SYMBOL_BITS-1:0] b_sym,
  output logic [LW-1:0]          score
);
  import lcswt_pkg::*;

  logic [1:0]    dir_mem [MAX_LEN];
  logic [LW-1:0] up;
  logic [LW-1:0] v;
  logic [1:0]    dir;
  logic          match;

  always_comb begin
    match = (a_in == b_sym);
    if (match) begin
      v   = diag_in + LW'(1);
      dir = DIR_DIAG;
    end else if (up > left_in) begin
      v   = up;
      dir = DIR_UP;
    end else begin
      v   = left_in;
      dir = DIR_LEFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
      up      <= '0;
    end else begin
      vld_out <= vld_in;
      if (clr) begin
        up <= '0;
      end else if (vld_in) begin
        up <= v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_sym <= b_in;
    end
    a_out    <= a_in;
    row_out  <= row_in;
    left_out <= v;
    diag_out <= up;
    if (vld_in) begin
      dir_mem[row_in] <= dir;
    end
    rd_dir <= dir_mem[rd_addr];
  end

  assign score = up;

endmodule

>>> sv/lcs_with_traceback_core.sv
// ---------------------------------------------------------------------------
// lcs_with_traceback_core
// Longest common subsequence with traceback over a systolic row of cells.
// ---------------------------------------------------------------------------
//
//  channel | dir | signals                     | contents
//  --------+-----+-----------------------------+---------------------------
//  s_      | in  | tvalid tready tdata tuser   | symbol, command
//  m_      | out | tvalid tready tdata tuser   | lcs symbol/length, flags
//                  tlast                       | last item of the run
//
//  Appends are taken one per cycle while the core is idle. A run sweeps
//  the first string, of length n, through the cell row; the traceback then
//  takes each step in S_TB and S_TB_STEP (registered direction read in
//  the cells), at most n + m steps for a second string of length m; each
//  result item is read in S_EM_RD (registered buffer), offered in S_EM_OUT.
//  s_tready is low from a run transaction until its last result is taken.
//  Reset is synchronous, active high; string stores hold no reset value.
//  A stall on m_ simply holds the current result.
// ---------------------------------------------------------------------------
module lcs_with_traceback_core #(
  parameter int MAX_LEN     = lcswt_pkg::DEF_MAX_LEN,
  parameter int SYMBOL_BITS = lcswt_pkg::DEF_SYMBOL_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] lcs_symbol, [14:8] lcs_length, [15] zero
  output logic [1:0]  m_tuser,   // [0] empty_res, [1] truncated
  output logic        m_tlast
);
  import lcswt_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int RW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int FW = $clog2(2 * MAX_LEN + 2);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FILL    = 3'd1;
  localparam logic [2:0] S_TB      = 3'd2;
  localparam logic [2:0] S_TB_STEP = 3'd3;
  localparam logic [2:0] S_EM_RD   = 3'd4;
  localparam logic [2:0] S_EM_OUT  = 3'd5;

  logic [2:0]             state;
  logic [LW-1:0]          n_len, m_len;
  logic                   dropped;
  logic [FW-1:0]          fc;
  logic [LW-1:0]          ti, tj, pos, len, k;
  logic [SYMBOL_BITS-1:0] rb_q;
  logic [SYMBOL_BITS-1:0] a_mem [MAX_LEN];
  logic [SYMBOL_BITS-1:0] r_mem [MAX_LEN];
  logic [SYMBOL_BITS-1:0] sym_in;
  logic                   s_acc, m_acc;

  // wavefront links, entry k feeds cell k
  logic                   vld_l  [MAX_LEN+1];
  logic [SYMBOL_BITS-1:0] a_l    [MAX_LEN+1];
  logic [RW-1:0]          row_l  [MAX_LEN+1];
  logic [LW-1:0]          left_l [MAX_LEN+1];
  logic [LW-1:0]          diag_l [MAX_LEN+1];
  logic [1:0]             dir_q  [MAX_LEN];
  logic [SYMBOL_BITS-1:0] b_q    [MAX_LEN];
  logic [LW-1:0]          sc_q   [MAX_LEN];
  logic [MAX_LEN-1:0]     b_we;
  logic [RW-1:0]          tb_addr;
  logic [LW-1:0]          jm1, mm1;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;
  assign sym_in   = SYMBOL_BITS'(s_tdata);
  assign jm1      = tj - LW'(1);
  assign mm1      = m_len - LW'(1);
  assign tb_addr  = RW'(ti - LW'(1));

  // first string store and the feed into cell 0
  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == CMD_APPEND_A && n_len < LW'(MAX_LEN)) begin
      a_mem[n_len[RW-1:0]] <= sym_in;
    end
    a_l[0]   <= a_mem[fc[RW-1:0]];
    row_l[0] <= fc[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_l[0] <= 1'b0;
    end else begin
      vld_l[0] <= (state == S_FILL) && (fc < FW'(n_len));
    end
  end

  assign left_l[0] = '0;
  assign diag_l[0] = '0;

  genvar g;
  generate
    for (g = 0; g < MAX_LEN; g++) begin : g_cell
      assign b_we[g] = s_acc && (s_tuser == CMD_APPEND_B) && (m_len == LW'(g));
      lcswt_cell #(
        .MAX_LEN(MAX_LEN), .SYMBOL_BITS(SYMBOL_BITS), .LW(LW), .RW(RW)
      ) u_cell (
        .clk(clk), .rst(rst),
        .clr(s_acc && s_tuser == CMD_RUN),
        .b_we(b_we[g]), .b_in(sym_in),
        .vld_in(vld_l[g]), .a_in(a_l[g]), .row_in(row_l[g]),
        .left_in(left_l[g]), .diag_in(diag_l[g]),
        .vld_out(vld_l[g+1]), .a_out(a_l[g+1]), .row_out(row_l[g+1]),
        .left_out(left_l[g+1]), .diag_out(diag_l[g+1]),
        .rd_addr(tb_addr), .rd_dir(dir_q[g]), .b_sym(b_q[g]), .score(sc_q[g])
      );
    end
  endgenerate

  // result buffer, filled backwards by the traceback
  always_ff @(posedge clk) begin
    if (state == S_TB_STEP && dir_q[jm1[RW-1:0]] == DIR_DIAG && pos != '0) begin
      r_mem[RW'(pos - LW'(1))] <= b_q[jm1[RW-1:0]];
    end
    rb_q <= r_mem[k[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      n_len   <= '0;
      m_len   <= '0;
      dropped <= 1'b0;
      fc      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            if (s_tuser == CMD_APPEND_A) begin
              if (n_len < LW'(MAX_LEN)) n_len <= n_len + LW'(1);
              else dropped <= 1'b1;
            end else if (s_tuser == CMD_APPEND_B) begin
              if (m_len < LW'(MAX_LEN)) m_len <= m_len + LW'(1);
              else dropped <= 1'b1;
            end else if (s_tuser == CMD_RUN) begin
              fc    <= '0;
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          fc <= fc + FW'(1);
          if (fc == FW'(n_len) + FW'(MAX_LEN + 1)) begin
            len   <= (m_len == '0) ? '0 : sc_q[mm1[RW-1:0]];
            pos   <= (m_len == '0) ? '0 : sc_q[mm1[RW-1:0]];
            ti    <= n_len;
            tj    <= m_len;
            state <= S_TB;
          end
        end
        S_TB: begin
          if (ti == '0 || tj == '0) begin
            k     <= '0;
            state <= S_EM_RD;
          end else begin
            state <= S_TB_STEP;
          end
        end
        S_TB_STEP: begin
          unique case (dir_q[jm1[RW-1:0]])
            DIR_DIAG: begin
              if (pos != '0) pos <= pos - LW'(1);
              ti <= ti - LW'(1);
              tj <= tj - LW'(1);
            end
            DIR_UP:  ti <= ti - LW'(1);
            default: tj <= tj - LW'(1);
          endcase
          state <= S_TB;
        end
        S_EM_RD: state <= S_EM_OUT;
        S_EM_OUT: begin
          if (m_acc) begin
            if (m_tlast) begin
              n_len   <= '0;
              m_len   <= '0;
              dropped <= 1'b0;
              state   <= S_IDLE;
            end else begin
              k     <= k + LW'(1);
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = (state == S_EM_OUT);
  assign m_tlast  = (len == '0) || (k + LW'(1) == len);
  assign m_tdata  = {1'b0, 7'(len), (len == '0) ? 8'd0 : 8'(rb_q)};
  assign m_tuser  = {dropped, (len == '0)};

endmodule

>>> sv/lcswt_checker.sv
// ---------------------------------------------------------------------------
// lcswt_checker
// Port-level checks for the LCS core, bound to the top level.
// ---------------------------------------------------------------------------
module lcswt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_no_input_during_output: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while a run is emitting");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && m_tdata[14:8] == 7'd0)
    else $error("empty result malformed");

  a_nonempty_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[14:8] != 7'd0)
    else $error("non-empty result with zero length");

endmodule

bind lcs_with_traceback_core lcswt_checker u_lcswt_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
